// ===== rtl/sss_pkg.sv =====
// Shared constants, types and command/status structs for the stock-span engine.
`default_nettype none

package sss_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = PTR_W + 1;
  localparam int unsigned SPAN_WIDTH  = 16;
  localparam int unsigned PRICE_WIDTH = 32;

  typedef logic signed [PRICE_WIDTH-1:0] price_t;
  typedef logic        [SPAN_WIDTH-1:0]  span_t;
  typedef logic        [PTR_W-1:0]       ptr_t;
  typedef logic        [CNT_W-1:0]       cnt_t;

  localparam span_t SPAN_MAX  = '1;
  localparam span_t SPAN_ONE  = span_t'(1);
  localparam cnt_t  DEPTH_CNT = cnt_t'(STACK_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_PUSH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch input beat
    logic read_top;  // read newest stack entry
    logic pop;       // fold top span into running span, drop top
    logic push;      // write entry, load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stack_empty;
    logic stack_full;
    logic top_le;    // top price <= current price
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/sss_if.sv =====
// Valid/ready channel interfaces for price input and span output beats.
`default_nettype none

interface sss_in_if;
  import sss_pkg::*;
  logic   valid;
  logic   ready;
  price_t price;
  logic   new_series;
  modport source(output valid, price, new_series, input ready);
  modport sink(input valid, price, new_series, output ready);
endinterface

interface sss_out_if;
  import sss_pkg::*;
  logic  valid;
  logic  ready;
  span_t span_days;
  logic  overflowed;
  modport source(output valid, span_days, overflowed, input ready);
  modport sink(input valid, span_days, overflowed, output ready);
endinterface

`default_nettype wire

// ===== rtl/sss_ctrl.sv =====
// Sequencer: accept, pop loop over the stack, push and result hand-off.
`default_nettype none

module sss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sss_pkg::status_t status_i,
  output sss_pkg::cmd_t         cmd_o
);
  import sss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = status_i.stack_empty ? ST_PUSH : ST_CMP;
      end
      ST_CMP: begin
        state_d = status_i.top_le ? ST_READ : ST_PUSH;
      end
      ST_PUSH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: begin
        cmd_o.read_top = !status_i.stack_empty;
      end
      ST_CMP: begin
        cmd_o.pop = status_i.top_le;
      end
      ST_PUSH: begin
        cmd_o.push = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sss_dpath.sv =====
// Stack memory, circular pointers, span accumulator and output register.
`default_nettype none

module sss_dpath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sss_pkg::cmd_t   cmd_i,
  input  wire sss_pkg::price_t price_i,
  input  wire logic            new_series_i,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output sss_pkg::span_t       span_days_o,
  output logic                 overflowed_o,
  output sss_pkg::status_t     status_o
);
  import sss_pkg::*;

  // stack storage, circular; head points at next free slot
  price_t mem_price [STACK_DEPTH];
  span_t  mem_span  [STACK_DEPTH];

  ptr_t   head_q;
  cnt_t   count_q;
  logic   ovf_q;
  logic   out_valid_q;

  price_t price_q;
  span_t  span_q;
  price_t rd_price_q;
  span_t  rd_span_q;
  span_t  out_span_q;
  logic   out_ovf_q;

  logic [SPAN_WIDTH:0] sum;
  span_t               span_sat;
  logic                full;
  ptr_t                top_ptr;

  assign full     = (count_q == DEPTH_CNT);
  assign top_ptr  = head_q - ptr_t'(1);
  assign sum      = {1'b0, span_q} + {1'b0, rd_span_q};
  assign span_sat = sum[SPAN_WIDTH] ? SPAN_MAX : sum[SPAN_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_price[head_q] <= price_q;
      mem_span[head_q]  <= span_q;
    end
    if (cmd_i.read_top) begin
      rd_price_q <= mem_price[top_ptr];
      rd_span_q  <= mem_span[top_ptr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      price_q <= price_i;
      span_q  <= SPAN_ONE;
    end else if (cmd_i.pop) begin
      span_q  <= span_sat;
    end
    if (cmd_i.push) begin
      out_span_q <= span_q;
      out_ovf_q  <= full | ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && new_series_i) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.pop) begin
        head_q  <= top_ptr;
        count_q <= count_q - cnt_t'(1);
      end else if (cmd_i.push) begin
        head_q <= head_q + ptr_t'(1);
        // full stack: slot at head is the oldest entry, overwrite it
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + cnt_t'(1);
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_days_o  = out_span_q;
  assign overflowed_o = out_ovf_q;

  assign status_o.stack_empty = (count_q == '0);
  assign status_o.stack_full  = full;
  assign status_o.top_le      = (rd_price_q <= price_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/stock_span_monotonic_stack.sv =====
// Top level of the streaming stock-span engine.
`default_nettype none

// Stock-span engine. Each input beat carries a signed 32-bit price and a
// new_series flag; each produces exactly one output beat with the span in days
// (16 bits, saturating at 65535) and a sticky overflowed flag. A 256-entry
// monotonic stack of (price, span) pairs lives in an on-chip memory with one
// write and one registered read port, used as a circular buffer: when the
// stack is full after popping, the push overwrites the oldest entry and
// overflowed stays set until new_series or reset. new_series empties the stack
// before its price is handled. Sequence: the item is accepted while idle, then
// the top entry is read and compared with its price; each entry that is
// popped costs a memory read plus a compare, which sets the rate. When the
// stack is empty at the read step, the compare is skipped and the push step
// follows; otherwise the first top entry with a higher price ends the loop and
// the push follows. The sequencer then returns to idle before the next accept.
// Amortized, an item pops at most one entry. Input is taken only while the
// sequencer is idle, but a finished result may wait in the output register
// while the next beat is accepted; the push step stalls only if that register
// is still full. No clearing pass follows reset.

module stock_span_monotonic_stack (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sss_in_if.sink     in_i,
  sss_out_if.source  out_o
);
  import sss_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  sss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  sss_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .price_i      (in_i.price),
    .new_series_i (in_i.new_series),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .span_days_o  (out_o.span_days),
    .overflowed_o (out_o.overflowed),
    .status_o     (status)
  );

  // A push always lands a result beat in the output register.
  a_push_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> out_o.valid)
    else $error("push did not produce an output beat");

  // Dropping the oldest entry must raise the sticky flag on that beat.
  a_full_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push && status.stack_full) |=> out_o.overflowed)
    else $error("overflow not flagged on full stack push");

  // Never read or pop an empty stack.
  a_no_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.read_top || cmd.pop) |-> !status.stack_empty)
    else $error("stack access while empty");

  // A pop follows only a read of the top entry in the previous cycle.
  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> $past(cmd.read_top))
    else $error("pop without preceding top read");

endmodule

`default_nettype wire
